/* src/assert_macros.svh */
// Assertion macros shared by the RTL files that check their own behaviour.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that a property holds at every rising edge outside reset.
`define SPKE_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Check that a condition never holds at a rising edge outside reset.
`define SPKE_NEVER(label, clk, rst, cond, msg) \
  `SPKE_ASSERT(label, clk, rst, !(cond), msg)

`endif

/* src/spke_pkg.sv */
// Shared types and codes of the Sobolev product kernel engine.
package spke_pkg;

  // Input command codes
  localparam logic CMD_STORE = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ISSUE,
    ST_DRAIN,
    ST_HOLD
  } state_t;

  // Controller to datapath commands
  typedef struct packed {
    logic start;
    logic store;
    logic rd_en;
    logic rd_last;
    logic out_load;
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic last_step;
  } sts_t;

endpackage

/* src/spke_ram.sv */
// Generic RAM: one write port, two read ports with registered read data.
module spke_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2048,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr_a,
  input  logic [AW-1:0]    raddr_b,
  output logic [WIDTH-1:0] rdata_a,
  output logic [WIDTH-1:0] rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

/* src/spke_ctrl.sv */
// Sequencer of the kernel engine: handshakes, dimension count and result hand-off.
module spke_ctrl #(
  parameter int MAX_DIMS = 8,
  localparam int DIW = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic              command,
  input  logic              cfg_wr_en,
  input  logic [3:0]        cfg_wr_data,
  output logic              out_valid,
  input  logic              out_stall,
  output spke_pkg::cmd_t    cmd,
  output logic [DIW-1:0]    rd_dim,
  input  spke_pkg::sts_t    sts
);
  import spke_pkg::*;

  localparam int NW = $clog2(MAX_DIMS + 1);

  state_t         state, state_next;
  logic [3:0]     dims;
  logic [DIW-1:0] dim_cnt, dim_cnt_next;
  logic [NW-1:0]  n_lat, n_lat_next;
  logic [NW-1:0]  n_cfg;
  logic           out_valid_next;
  logic           accept;
  logic           last_dim;

  // Counts above the store's dimension count are held at that count
  assign n_cfg    = (int'(dims) > MAX_DIMS) ? NW'(MAX_DIMS) : NW'(dims);
  assign last_dim = (NW'(dim_cnt) + NW'(1)) == n_lat;
  assign in_stall = (state != ST_IDLE);
  assign accept   = in_valid && !in_stall;
  assign rd_dim   = dim_cnt;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      dims      <= 4'd1;
      dim_cnt   <= '0;
      n_lat     <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      dim_cnt   <= dim_cnt_next;
      n_lat     <= n_lat_next;
      out_valid <= out_valid_next;
      if (cfg_wr_en) begin
        dims <= cfg_wr_data;
      end
    end
  end

  always_comb begin
    state_next   = state;
    dim_cnt_next = dim_cnt;
    n_lat_next   = n_lat;
    cmd          = '0;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          if (command == CMD_STORE) begin
            cmd.store = 1'b1;
          end else begin
            cmd.start    = 1'b1;
            dim_cnt_next = '0;
            n_lat_next   = n_cfg;
            state_next   = (n_cfg == '0) ? ST_HOLD : ST_ISSUE;
          end
        end
      end
      ST_ISSUE: begin
        cmd.rd_en   = 1'b1;
        cmd.rd_last = last_dim;
        if (last_dim) begin
          state_next = ST_DRAIN;
        end else begin
          dim_cnt_next = dim_cnt + DIW'(1);
        end
      end
      ST_DRAIN: begin
        if (sts.last_step) begin
          state_next = ST_HOLD;
        end
      end
      ST_HOLD: begin
        if (!out_valid || !out_stall) begin
          cmd.out_load = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  assign out_valid_next = cmd.out_load || (out_valid && out_stall);

endmodule

/* src/spke_datapath.sv */
// Coordinate store, per-dimension factor pipeline, product accumulator and result register.
module spke_datapath #(
  parameter int MAX_POINTS = 256,
  parameter int MAX_DIMS   = 8,
  parameter int COORD_BITS = 16,
  localparam int DIW = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1
) (
  input  logic              clk,
  input  logic              rst,
  input  spke_pkg::cmd_t    cmd,
  input  logic [DIW-1:0]    rd_dim,
  output spke_pkg::sts_t    sts,
  input  logic [7:0]        point_index,
  input  logic [2:0]        dim_index,
  input  logic [15:0]       coord_value,
  input  logic [7:0]        other_index,
  output logic [31:0]       kernel_value,
  output logic              saturated,
  output logic [7:0]        row_echo,
  output logic [7:0]        col_echo
);
  import spke_pkg::*;

  localparam int PW    = $clog2(MAX_POINTS);
  localparam int DEPTH = MAX_POINTS * MAX_DIMS;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int NSTG  = 8;

  localparam logic signed [30:0] HALF31    = 31'sd536870912;
  localparam logic signed [30:0] TWELFTH31 = 31'sd89478485;
  localparam logic signed [29:0] SEV240_30 = 30'sd31317470;
  localparam logic signed [31:0] ONE32     = 32'sd1073741824;
  localparam logic [23:0]        RECIP3    = 24'hAAAAAB;
  localparam logic [31:0]        Q24_ONE   = 32'h0100_0000;
  localparam logic [31:0]        KVAL_MAX  = 32'hFFFF_FFFF;

  typedef logic [PW-1:0]  pwrap_t [256];
  typedef logic [DIW-1:0] dwrap_t [8];

  function automatic pwrap_t build_pwrap();
    pwrap_t t;
    for (int i = 0; i < 256; i++) begin
      t[i] = PW'(i % MAX_POINTS);
    end
    return t;
  endfunction

  function automatic dwrap_t build_dwrap();
    dwrap_t t;
    for (int i = 0; i < 8; i++) begin
      t[i] = DIW'(i % MAX_DIMS);
    end
    return t;
  endfunction

  localparam pwrap_t PWRAP = build_pwrap();
  localparam dwrap_t DWRAP = build_dwrap();

  // Q30 product rounded to nearest, ties away from zero
  function automatic logic signed [31:0] qround(input logic signed [63:0] p);
    logic [63:0] mag;
    logic [63:0] q;
    mag = p[63] ? 64'(-p) : 64'(p);
    q   = (mag + 64'd536870912) >> 30;
    return p[63] ? -$signed(q[31:0]) : $signed(q[31:0]);
  endfunction

  // Halve, rounding to nearest, ties away from zero
  function automatic logic signed [30:0] divr2(input logic signed [30:0] x);
    logic [30:0] mag;
    logic [30:0] q;
    mag = x[30] ? 31'(-x) : 31'(x);
    q   = (mag + 31'd1) >> 1;
    return x[30] ? -$signed(q) : $signed(q);
  endfunction

  // Query operands
  logic [PW-1:0] p_lat, q_lat;
  logic [7:0]    row_lat, col_lat;
  logic [AW-1:0] waddr, raddr_s, raddr_t;
  logic [COORD_BITS-1:0] rd_s, rd_t;

  assign waddr   = AW'(PWRAP[point_index]) * AW'(MAX_DIMS) + AW'(DWRAP[dim_index]);
  assign raddr_s = AW'(p_lat) * AW'(MAX_DIMS) + AW'(rd_dim);
  assign raddr_t = AW'(q_lat) * AW'(MAX_DIMS) + AW'(rd_dim);

  spke_ram #(
    .WIDTH (COORD_BITS),
    .DEPTH (DEPTH)
  ) u_store (
    .clk     (clk),
    .we      (cmd.store),
    .waddr   (waddr),
    .wdata   (COORD_BITS'(coord_value)),
    .raddr_a (raddr_s),
    .raddr_b (raddr_t),
    .rdata_a (rd_s),
    .rdata_b (rd_t)
  );

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      p_lat   <= PWRAP[point_index];
      q_lat   <= PWRAP[other_index];
      row_lat <= point_index;
      col_lat <= other_index;
    end
  end

  // Valid and last tags travelling with each dimension
  logic [NSTG-1:0] vld, lst;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
      lst <= '0;
    end else begin
      vld <= {vld[NSTG-2:0], cmd.rd_en};
      lst <= {lst[NSTG-2:0], cmd.rd_last};
    end
  end

  assign sts.last_step = vld[NSTG-1] && lst[NSTG-1];

  // Stage 1: centre coordinates and distance
  logic [29:0] sq, tq, diff;
  logic signed [30:0] s1_k1s, s1_k1t, s1_a;

  assign sq   = {rd_s, {(30 - COORD_BITS){1'b0}}};
  assign tq   = {rd_t, {(30 - COORD_BITS){1'b0}}};
  assign diff = (sq >= tq) ? sq - tq : tq - sq;

  always_ff @(posedge clk) begin
    s1_k1s <= $signed({1'b0, sq}) - HALF31;
    s1_k1t <= $signed({1'b0, tq}) - HALF31;
    s1_a   <= $signed({1'b0, diff}) - HALF31;
  end

  // Stage 2: first squares and cross product
  logic signed [61:0] p_st, p_ss, p_tt, p_aa;
  logic signed [31:0] m1_w, m2_w, m3_w, a2_w;
  logic signed [29:0] s2_m1, s2_m2, s2_m3;
  logic [28:0] s2_a2;

  assign p_st = s1_k1s * s1_k1t;
  assign p_ss = s1_k1s * s1_k1s;
  assign p_tt = s1_k1t * s1_k1t;
  assign p_aa = s1_a * s1_a;
  assign m1_w = qround(64'(p_st));
  assign m2_w = qround(64'(p_ss));
  assign m3_w = qround(64'(p_tt));
  assign a2_w = qround(64'(p_aa));

  always_ff @(posedge clk) begin
    s2_m1 <= m1_w[29:0];
    s2_m2 <= m2_w[29:0];
    s2_m3 <= m3_w[29:0];
    s2_a2 <= a2_w[28:0];
  end

  // Stage 3: second-order terms and halved square of the distance
  logic signed [30:0] k2s_w, k2t_w;
  logic signed [29:0] s3_k2s, s3_k2t, s3_m1;
  logic [28:0] s3_a2, s3_h;

  assign k2s_w = divr2(31'(s2_m2) - TWELFTH31);
  assign k2t_w = divr2(31'(s2_m3) - TWELFTH31);

  always_ff @(posedge clk) begin
    s3_k2s <= k2s_w[29:0];
    s3_k2t <= k2t_w[29:0];
    s3_m1  <= s2_m1;
    s3_a2  <= s2_a2;
    s3_h   <= (s2_a2 + 29'd1) >> 1;
  end

  // Stage 4: product of second-order terms and fourth power
  logic signed [59:0] p_k2;
  logic signed [59:0] p_a4;
  logic signed [31:0] m4_w, a4_w;
  logic signed [29:0] s4_m1, s4_m4;
  logic [26:0] s4_a4;
  logic [28:0] s4_h;

  assign p_k2 = s3_k2s * s3_k2t;
  assign p_a4 = $signed({1'b0, s3_a2}) * $signed({1'b0, s3_a2});
  assign m4_w = qround(64'(p_k2));
  assign a4_w = qround(64'(p_a4));

  always_ff @(posedge clk) begin
    s4_m1 <= s3_m1;
    s4_m4 <= m4_w[29:0];
    s4_a4 <= a4_w[26:0];
    s4_h  <= s3_h;
  end

  // Stage 5: fourth-order numerator, prepared for the divide by 24
  logic signed [29:0] num_w;
  logic [29:0] num_mag;
  logic [29:0] num_rnd;
  logic        s5_neg;
  logic [24:0] s5_y;
  logic signed [31:0] s5_base;

  assign num_w   = $signed({3'b0, s4_a4}) - $signed({1'b0, s4_h}) + SEV240_30;
  assign num_mag = num_w[29] ? 30'(-num_w) : 30'(num_w);
  assign num_rnd = (num_mag + 30'd12) >> 3;

  always_ff @(posedge clk) begin
    s5_neg  <= num_w[29];
    s5_y    <= num_rnd[24:0];
    s5_base <= ONE32 + 32'(s4_m1) + 32'(s4_m4);
  end

  // Stage 6: divide by three through the reciprocal
  logic [48:0] p_div;
  logic [23:0] k4_mag;
  logic signed [24:0] s6_k4;
  logic signed [31:0] s6_base;

  assign p_div  = s5_y * RECIP3;
  assign k4_mag = p_div[48:25];

  always_ff @(posedge clk) begin
    s6_k4   <= s5_neg ? -$signed({1'b0, k4_mag}) : $signed({1'b0, k4_mag});
    s6_base <= s5_base;
  end

  // Stage 7: factor, clamped at zero
  logic signed [31:0] fac_w;
  logic [30:0] s7_f;

  assign fac_w = s6_base - 32'(s6_k4);

  always_ff @(posedge clk) begin
    s7_f <= fac_w[31] ? 31'd0 : fac_w[30:0];
  end

  // Accumulate the product in Q8.24 with sticky saturation
  logic [31:0] acc;
  logic        sat;
  logic [62:0] p_acc;
  logic [63:0] acc_rnd;

  assign p_acc   = acc * s7_f;
  assign acc_rnd = (64'(p_acc) + 64'd536870912) >> 30;

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      acc <= Q24_ONE;
      sat <= 1'b0;
    end else if (vld[NSTG-1]) begin
      if (acc_rnd[63:32] != '0) begin
        acc <= KVAL_MAX;
        sat <= 1'b1;
      end else begin
        acc <= acc_rnd[31:0];
      end
    end
  end

  // Load the whole result at once so a stalled result holds while the next query runs
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      kernel_value <= acc;
      saturated    <= sat;
      row_echo     <= row_lat;
      col_echo     <= col_lat;
    end
  end

endmodule

/* src/sobolev_product_kernel_engine.sv */
// Top level of the Sobolev product kernel engine.
//
//   channel | handshake            | payload
//   --------+----------------------+----------------------------------------------
//   in      | in_valid / in_stall  | command, point_index, dim_index,
//           |                      | coord_value, other_index
//   out     | out_valid / out_stall| kernel_value, saturated, row_echo, col_echo
//   cfg     | cfg_wr_en            | cfg_wr_data (dims_in_use)
//
// A store transaction is written as it is accepted, and the next can follow at once. A
// query reads the coordinate store once per dimension in use, and an eight-stage factor
// pipeline feeds the product accumulator; the next transaction is taken in the cycle the
// result appears. With no dimensions in use a query goes straight to the result hand-off.
// Reset is synchronous and clears the sequencer, the result flag and dims_in_use (to 1);
// the store is not cleared.
// A stalled result holds in the output register; a finished query waits for it.
module sobolev_product_kernel_engine #(
  parameter int MAX_POINTS = 256,
  parameter int MAX_DIMS   = 8,
  parameter int COORD_BITS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        command,
  input  logic [7:0]  point_index,
  input  logic [2:0]  dim_index,
  input  logic [15:0] coord_value,
  input  logic [7:0]  other_index,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] kernel_value,
  output logic        saturated,
  output logic [7:0]  row_echo,
  output logic [7:0]  col_echo,
  input  logic        cfg_wr_en,
  input  logic [3:0]  cfg_wr_data
);
  import spke_pkg::*;

  `include "assert_macros.svh"

  localparam int DIW = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;

  cmd_t           cmd;
  sts_t           sts;
  logic [DIW-1:0] rd_dim;

  // Sequencer: accepts transactions, walks the dimensions, hands off the result
  spke_ctrl #(
    .MAX_DIMS (MAX_DIMS)
  ) u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .command     (command),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .cmd         (cmd),
    .rd_dim      (rd_dim),
    .sts         (sts)
  );

  // Datapath: store, factor pipeline, accumulator and output register
  spke_datapath #(
    .MAX_POINTS (MAX_POINTS),
    .MAX_DIMS   (MAX_DIMS),
    .COORD_BITS (COORD_BITS)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .rd_dim       (rd_dim),
    .sts          (sts),
    .point_index  (point_index),
    .dim_index    (dim_index),
    .coord_value  (coord_value),
    .other_index  (other_index),
    .kernel_value (kernel_value),
    .saturated    (saturated),
    .row_echo     (row_echo),
    .col_echo     (col_echo)
  );

  // Never overwrite a result that is still waiting to be taken
  `SPKE_NEVER(a_no_overwrite, clk, rst, cmd.out_load && out_valid && out_stall, "result overwritten while stalled")

  // Store reads only while the input side is blocked, so no write can collide
  `SPKE_ASSERT(a_read_blocks_input, clk, rst, cmd.rd_en |-> in_stall, "store read while input open")

  // A store transaction never produces a result
  `SPKE_ASSERT(a_store_no_result, clk, rst, (in_valid && !in_stall && command == CMD_STORE) |=> !$rose(out_valid), "store produced a result")

endmodule
